/* hdl/edf_pkg.sv */
// types and constants shared by the edf scheduler modules
// no dependencies

package edf_pkg;

   localparam int DEF_MAX_JOBS = 64;
   localparam int TICK_W       = 23;
   localparam int WAIT_W       = 29;
   localparam int REQ_DATA_W   = 56;
   localparam int RSP_DATA_W   = 112;

   typedef struct packed {
      logic [15:0] due;
      logic [15:0] len;
      logic [15:0] rel;
      logic [7:0]  tag;
   } job_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_RESOLVE,
      ST_EMIT
   } state_type;

   // scan control from the sequencer to the pick unit
   typedef struct packed {
      logic scan_en;
      logic pass_start;
      logic mark_en;
   } scan_ctl_type;

endpackage

/* hdl/edf_nonpreemptive_scheduler.sv */
// top level of the non-preemptive edf scheduler: ring of job cells, pick unit
// and sequencer; depends on edf_pkg, edf_cell, edf_pick
// operation: each pick is one full rotation of the ring past the pick unit,
// then a resolve step and then the result transaction.
// loads are refused while a schedule runs; reset empties the ring and returns
// the block to loading.

module edf_nonpreemptive_scheduler
   import edf_pkg::*;
#(
   parameter int MAX_JOBS = DEF_MAX_JOBS
) (
   input  logic                  clock,
   input  logic                  reset,
   // tdata: task_tag, release_at, run_length, due_at
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: out_tag, out_release, start_tick, out_length, out_due, wait_total, pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready
);

   localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W = $clog2(MAX_JOBS + 1);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  done_ff, done_in;
   logic [IDX_W-1:0]  pass_ff, pass_in;
   logic [IDX_W-1:0]  pick_ff, pick_in;
   logic [TICK_W-1:0] now_ff, now_in;
   logic [WAIT_W-1:0] wait_ff, wait_in;
   logic              first_ff, first_in;
   job_type           res_job_ff;
   logic [TICK_W-1:0] res_start_ff;
   logic [WAIT_W-1:0] res_wait_ff;
   logic              res_last_ff;

   job_type           cj [MAX_JOBS];
   logic [IDX_W-1:0]  ci [MAX_JOBS];
   logic              cs [MAX_JOBS];
   logic              cv [MAX_JOBS];
   job_type           tail_job;
   logic [IDX_W-1:0]  tail_idx;
   logic              tail_served, tail_valid;

   logic              load_acc, store_ok, shift_en, clear_all, rsp_acc, pass_end;
   logic              is_last;
   scan_ctl_type      ctl;
   logic              head_taken, any_rdy;
   job_type           best_rdy_job, best_min_job, sel_job;
   logic [IDX_W-1:0]  best_rdy_idx, best_min_idx, sel_idx;
   logic              use_min;
   logic [TICK_W-1:0] start_tick;
   job_type           new_job;

   assign new_job  = job_type'(req_tdata);
   assign load_acc = req_tvalid && req_tready;
   assign rsp_acc  = rsp_tvalid && rsp_tready;
   assign store_ok = count_ff < CNT_W'(MAX_JOBS);
   assign pass_end = pass_ff == IDX_W'(MAX_JOBS - 1);
   assign is_last  = (done_ff + CNT_W'(1)) == count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (load_acc && req_tlast) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (pass_end) state_in = ST_RESOLVE;
         end
         ST_RESOLVE: state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_acc) state_in = res_last_ff ? ST_LOAD : ST_SCAN;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready     = 1'b0;
      rsp_tvalid     = 1'b0;
      ctl.scan_en    = 1'b0;
      ctl.pass_start = 1'b0;
      ctl.mark_en    = 1'b0;
      shift_en       = 1'b0;
      clear_all      = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            shift_en   = req_tvalid && store_ok;
         end
         ST_SCAN: begin
            ctl.scan_en    = 1'b1;
            ctl.pass_start = pass_ff == '0;
            ctl.mark_en    = !first_ff;
            shift_en       = 1'b1;
         end
         ST_RESOLVE: ;
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            clear_all  = rsp_tready && res_last_ff;
         end
         default: ;
      endcase
   end

   // ring tail input: new load or the head coming round
   always_comb begin
      if (state_ff == ST_LOAD) begin
         tail_job    = new_job;
         tail_idx    = count_ff[IDX_W-1:0];
         tail_served = 1'b0;
         tail_valid  = 1'b1;
      end else begin
         tail_job    = cj[0];
         tail_idx    = ci[0];
         tail_served = cs[0] || head_taken;
         tail_valid  = cv[0];
      end
   end

   // chain of cells, head at position zero
   for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
      job_type          dj;
      logic [IDX_W-1:0] di;
      logic             ds, dv;
      if (g == MAX_JOBS - 1) begin : g_tail
         assign dj = tail_job;
         assign di = tail_idx;
         assign ds = tail_served;
         assign dv = tail_valid;
      end else begin : g_mid
         assign dj = cj[g+1];
         assign di = ci[g+1];
         assign ds = cs[g+1];
         assign dv = cv[g+1];
      end
      edf_cell #(.IDX_W(IDX_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .clear_all(clear_all),
         .d_job    (dj),
         .d_idx    (di),
         .d_served (ds),
         .d_valid  (dv),
         .q_job    (cj[g]),
         .q_idx    (ci[g]),
         .q_served (cs[g]),
         .q_valid  (cv[g])
      );
   end

   edf_pick #(.IDX_W(IDX_W)) u_pick (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .head_job    (cj[0]),
      .head_idx    (ci[0]),
      .head_served (cs[0]),
      .head_valid  (cv[0]),
      .pick_idx    (pick_ff),
      .now_tick    (now_ff),
      .head_taken  (head_taken),
      .any_rdy     (any_rdy),
      .best_rdy_job(best_rdy_job),
      .best_rdy_idx(best_rdy_idx),
      .best_min_job(best_min_job),
      .best_min_idx(best_min_idx)
   );

   // idle processor or first pick: time jumps to the earliest release
   assign use_min    = first_ff || !any_rdy;
   assign sel_job    = use_min ? best_min_job : best_rdy_job;
   assign sel_idx    = use_min ? best_min_idx : best_rdy_idx;
   assign start_tick = use_min ? {{(TICK_W-16){1'b0}}, best_min_job.rel} : now_ff;

   // schedule bookkeeping
   always_comb begin
      count_in = count_ff;
      done_in  = done_ff;
      pass_in  = pass_ff;
      pick_in  = pick_ff;
      now_in   = now_ff;
      wait_in  = wait_ff;
      first_in = first_ff;
      case (state_ff)
         ST_LOAD: begin
            if (load_acc && store_ok) count_in = count_ff + CNT_W'(1);
            pass_in  = '0;
            done_in  = '0;
            now_in   = '0;
            wait_in  = '0;
            first_in = 1'b1;
         end
         ST_SCAN: pass_in = pass_end ? '0 : pass_ff + IDX_W'(1);
         ST_RESOLVE: begin
            pick_in = sel_idx;
            now_in  = start_tick + {{(TICK_W-16){1'b0}}, sel_job.len};
            wait_in = wait_ff + {{(WAIT_W-TICK_W){1'b0}},
                      start_tick - {{(TICK_W-16){1'b0}}, sel_job.rel}};
         end
         ST_EMIT: begin
            if (rsp_acc) begin
               done_in  = done_ff + CNT_W'(1);
               first_in = 1'b0;
               if (res_last_ff) count_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         done_ff  <= '0;
         pass_ff  <= '0;
         pick_ff  <= '0;
         now_ff   <= '0;
         wait_ff  <= '0;
         first_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         done_ff  <= done_in;
         pass_ff  <= pass_in;
         pick_ff  <= pick_in;
         now_ff   <= now_in;
         wait_ff  <= wait_in;
         first_ff <= first_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (state_ff == ST_RESOLVE) begin
         res_job_ff   <= sel_job;
         res_start_ff <= start_tick;
         res_wait_ff  <= wait_in;
         res_last_ff  <= is_last;
      end
   end

   assign rsp_tdata = {4'b0, res_wait_ff, res_job_ff.due, res_job_ff.len,
                       res_start_ff, res_job_ff.rel, res_job_ff.tag};
   assign rsp_tlast = res_last_ff;

endmodule

/* hdl/edf_cell.sv */
// one storage cell of the job ring: job, load index, served and valid bits
// depends on edf_pkg

module edf_cell
   import edf_pkg::*;
#(
   parameter int IDX_W = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift_en,
   input  logic             clear_all,
   input  job_type          d_job,
   input  logic [IDX_W-1:0] d_idx,
   input  logic             d_served,
   input  logic             d_valid,
   output job_type          q_job,
   output logic [IDX_W-1:0] q_idx,
   output logic             q_served,
   output logic             q_valid
);

   job_type          job_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             served_ff;
   logic             valid_ff;

   // payload moves one place along the ring
   always_ff @(posedge clock) begin
      if (shift_en) begin
         job_ff    <= d_job;
         idx_ff    <= d_idx;
         served_ff <= d_served;
      end
   end

   // occupancy
   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= d_valid;
      end
   end

   assign q_job    = job_ff;
   assign q_idx    = idx_ff;
   assign q_served = served_ff;
   assign q_valid  = valid_ff;

endmodule

/* hdl/edf_pick.sv */
// pick unit at the head of the ring: tracks the best released job and the
// earliest-release job over one pass; depends on edf_pkg

module edf_pick
   import edf_pkg::*;
#(
   parameter int IDX_W = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  scan_ctl_type      ctl,
   input  job_type           head_job,
   input  logic [IDX_W-1:0]  head_idx,
   input  logic              head_served,
   input  logic              head_valid,
   input  logic [IDX_W-1:0]  pick_idx,
   input  logic [TICK_W-1:0] now_tick,
   output logic              head_taken,
   output logic              any_rdy,
   output job_type           best_rdy_job,
   output logic [IDX_W-1:0]  best_rdy_idx,
   output job_type           best_min_job,
   output logic [IDX_W-1:0]  best_min_idx
);

   logic             rdy_any_ff, rdy_any_in;
   job_type          rdy_job_ff;
   logic [IDX_W-1:0] rdy_idx_ff;
   logic             min_any_ff, min_any_in;
   job_type          min_job_ff;
   logic [IDX_W-1:0] min_idx_ff;
   logic             elig, released, rdy_better, min_better, rdy_take, min_take;
   logic             rdy_have, min_have;

   // the job picked last time is marked as it passes the head
   assign head_taken = ctl.mark_en && (head_idx == pick_idx);
   assign elig       = head_valid && !head_served && !head_taken;
   assign released   = {{(TICK_W-16){1'b0}}, head_job.rel} <= now_tick;

   assign rdy_have = rdy_any_ff && !ctl.pass_start;
   assign min_have = min_any_ff && !ctl.pass_start;

   // deadline first, then release, then load order
   assign rdy_better = (head_job.due < rdy_job_ff.due) ||
      ((head_job.due == rdy_job_ff.due) && ((head_job.rel < rdy_job_ff.rel) ||
      ((head_job.rel == rdy_job_ff.rel) && (head_idx < rdy_idx_ff))));
   // release first, then deadline, then load order
   assign min_better = (head_job.rel < min_job_ff.rel) ||
      ((head_job.rel == min_job_ff.rel) && ((head_job.due < min_job_ff.due) ||
      ((head_job.due == min_job_ff.due) && (head_idx < min_idx_ff))));

   assign rdy_take   = ctl.scan_en && elig && released && (!rdy_have || rdy_better);
   assign min_take   = ctl.scan_en && elig && (!min_have || min_better);
   assign rdy_any_in = ctl.scan_en ? (rdy_have || rdy_take) : rdy_any_ff;
   assign min_any_in = ctl.scan_en ? (min_have || min_take) : min_any_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rdy_any_ff <= 1'b0;
         min_any_ff <= 1'b0;
      end else begin
         rdy_any_ff <= rdy_any_in;
         min_any_ff <= min_any_in;
      end
   end

   // best candidates
   always_ff @(posedge clock) begin
      if (rdy_take) begin
         rdy_job_ff <= head_job;
         rdy_idx_ff <= head_idx;
      end
      if (min_take) begin
         min_job_ff <= head_job;
         min_idx_ff <= head_idx;
      end
   end

   assign any_rdy      = rdy_any_ff;
   assign best_rdy_job = rdy_job_ff;
   assign best_rdy_idx = rdy_idx_ff;
   assign best_min_job = min_job_ff;
   assign best_min_idx = min_idx_ff;

endmodule

/* hdl/edf_checker.sv */
// port-level checks for the edf scheduler, bound to the top level
// depends on edf_pkg

module edf_checker
   import edf_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic                  rsp_tlast,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // loading and result delivery never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("load and result at once");

   // after the last result the block loads again
   a_back_to_load: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && !rsp_tvalid)
      else $error("no return to loading");

   // out of reset the block loads and shows no result
   a_reset_state: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("bad state after reset");

endmodule

bind edf_nonpreemptive_scheduler edf_checker u_edf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tlast (rsp_tlast),
   .rsp_tdata (rsp_tdata)
);
